// ----- hdl/mnpt_pkg.sv -----
// shared types, codes and constants of the monophonic note priority tracker
package mnpt_pkg;

	localparam int NUM_KEYS_DEF = 128;
	localparam int NOTE_W = 7;
	localparam int VEL_W = 7;
	localparam int CNT_W = 8;
	localparam int CUR_W = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int GRP_SIZE = 8;
	localparam int GRP_IDX_W = 3;

	localparam logic [CUR_W-1:0] NOTE_NONE = 8'hFF;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_ON   = 2'd1,
		EV_OFF  = 2'd2
	} ev_kind_t;

	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_PRESS   = 2'd1,
		OP_RELEASE = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SCAN = 2'd1,
		BK_PICK = 2'd2
	} bk_state_t;

endpackage

// ----- hdl/mnpt_evt_if.sv -----
// note event channel
interface mnpt_evt_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [mnpt_pkg::NOTE_W-1:0] note;
	logic [mnpt_pkg::VEL_W-1:0]  velocity;

	modport source (output valid, func, note, velocity, input ready);
	modport sink (input valid, func, note, velocity, output ready);
endinterface

// ----- hdl/mnpt_res_if.sv -----
// result channel
interface mnpt_res_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         event_kind;
	logic [mnpt_pkg::NOTE_W-1:0]        event_note;
	logic [mnpt_pkg::VEL_W-1:0]         event_velocity;
	logic [mnpt_pkg::CNT_W-1:0]         held_count;
	logic signed [mnpt_pkg::CUR_W-1:0]  current_note;
	logic [mnpt_pkg::VEL_W-1:0]         current_velocity;

	modport source (output valid, event_kind, event_note, event_velocity, held_count,
		current_note, current_velocity, input ready);
	modport sink (input valid, event_kind, event_note, event_velocity, held_count,
		current_note, current_velocity, output ready);
endinterface

// ----- hdl/mnpt_front.sv -----
// front end: takes note events and classifies them into press, release or ignore
module mnpt_front #(
	parameter int NUM_KEYS = mnpt_pkg::NUM_KEYS_DEF
) (
	mnpt_evt_if.sink        evt,
	input  logic            q_full,
	output logic            push,
	output mnpt_pkg::op_t   op
);

	localparam logic [mnpt_pkg::CNT_W-1:0] KEY_LIMIT = mnpt_pkg::CNT_W'(NUM_KEYS);

	logic in_range;

	assign evt.ready = !q_full;
	assign push = evt.valid && evt.ready;
	assign in_range = mnpt_pkg::CNT_W'(evt.note) < KEY_LIMIT;

	always_comb begin
		op.note = evt.note;
		op.velocity = evt.velocity;
		if (!in_range) begin
			op.kind = mnpt_pkg::OP_NONE;
		end else if (evt.func && (evt.velocity != '0)) begin
			op.kind = mnpt_pkg::OP_PRESS;
		end else begin
			// note on with zero velocity also lands here
			op.kind = mnpt_pkg::OP_RELEASE;
		end
	end

endmodule

// ----- hdl/mnpt_queue.sv -----
// short queue of classified operations between front and back
module mnpt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mnpt_pkg::op_t push_op,
	input  logic          pop,
	output mnpt_pkg::op_t head_op,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = mnpt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	mnpt_pkg::op_t      slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic               do_push;
	logic               do_pop;

	assign full = (fill_q == FILL_MAX);
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_op = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/mnpt_back.sv -----
// back end: held-key bitmap, highest-key search and the result register
module mnpt_back #(
	parameter int NUM_KEYS = mnpt_pkg::NUM_KEYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mnpt_pkg::op_t  head_op,
	input  logic           q_empty,
	output logic           pop,
	mnpt_res_if.source     res
);

	localparam int KW = $clog2(NUM_KEYS);
	localparam int GS = mnpt_pkg::GRP_SIZE;
	localparam int NG = (NUM_KEYS + GS - 1) / GS;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int PADW = NG * GS;
	localparam int IW = mnpt_pkg::GRP_IDX_W;
	localparam int CW = mnpt_pkg::CNT_W;
	localparam int UW = mnpt_pkg::CUR_W;
	localparam int VW = mnpt_pkg::VEL_W;
	localparam int NW = mnpt_pkg::NOTE_W;
	localparam logic [CW-1:0] KEY_LIMIT = CW'(NUM_KEYS);

	mnpt_pkg::bk_state_t state_q, state_d;

	logic [NUM_KEYS-1:0] held_q, held_d;
	logic [CW-1:0]       total_q, total_d;
	logic [UW-1:0]       active_q, active_d;
	logic [VW-1:0]       avel_q, avel_d;

	// per-group summary of the bitmap, first step of the highest-key search
	logic [NG-1:0]       grp_any_s1;
	logic [IW-1:0]       grp_idx_s1 [NG];
	logic [PADW-1:0]     held_pad;
	logic [NG-1:0]       grp_any;
	logic [IW-1:0]       grp_idx [NG];
	logic [GW-1:0]       grp_sel;
	logic [UW-1:0]       pick_note;

	logic                out_valid_q;
	logic [1:0]          ev_kind_q, ev_kind_d;
	logic [NW-1:0]       ev_note_q, ev_note_d;
	logic [VW-1:0]       ev_vel_q, ev_vel_d;
	logic [CW-1:0]       res_cnt_q;
	logic [UW-1:0]       res_cur_q;
	logic [VW-1:0]       res_vel_q;

	logic                slot_free;
	logic                load_res;
	logic                scan_start;
	logic [KW-1:0]       key;

	assign held_pad = PADW'(held_q);
	assign key = head_op.note[KW-1:0];
	assign slot_free = !out_valid_q || res.ready;

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |held_pad[g*GS +: GS];
			grp_idx[g] = '0;
			for (int b = 0; b < GS; b++) begin
				if (held_pad[g*GS + b]) begin
					grp_idx[g] = IW'(b);
				end
			end
		end
	end

	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NG; g++) begin
			if (grp_any_s1[g]) begin
				grp_sel = GW'(g);
			end
		end
		pick_note = UW'({grp_sel, grp_idx_s1[grp_sel]});
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load_res = 1'b0;
		scan_start = 1'b0;
		held_d = held_q;
		total_d = total_q;
		active_d = active_q;
		avel_d = avel_q;
		ev_kind_d = mnpt_pkg::EV_NONE;
		ev_note_d = '0;
		ev_vel_d = '0;
		case (state_q)
			mnpt_pkg::BK_IDLE: begin
				if (!q_empty && slot_free) begin
					pop = 1'b1;
					load_res = 1'b1;
					case (head_op.kind)
						mnpt_pkg::OP_PRESS: begin
							if (!held_q[key]) begin
								held_d[key] = 1'b1;
								total_d = total_q + 1'b1;
							end
							if (UW'(head_op.note) != active_q) begin
								active_d = UW'(head_op.note);
								avel_d = head_op.velocity;
								ev_kind_d = mnpt_pkg::EV_ON;
								ev_note_d = head_op.note;
								ev_vel_d = head_op.velocity;
							end
						end
						mnpt_pkg::OP_RELEASE: begin
							if (held_q[key]) begin
								held_d[key] = 1'b0;
								total_d = total_q - 1'b1;
								if (total_q == CW'(1)) begin
									active_d = mnpt_pkg::NOTE_NONE;
									ev_kind_d = mnpt_pkg::EV_OFF;
									ev_note_d = head_op.note;
									ev_vel_d = avel_q;
								end else begin
									// other keys still held, search for the highest
									load_res = 1'b0;
									scan_start = 1'b1;
									state_d = mnpt_pkg::BK_SCAN;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			mnpt_pkg::BK_SCAN: begin
				state_d = mnpt_pkg::BK_PICK;
			end
			mnpt_pkg::BK_PICK: begin
				load_res = 1'b1;
				active_d = pick_note;
				state_d = mnpt_pkg::BK_IDLE;
			end
			default: begin
				state_d = mnpt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mnpt_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			total_q <= '0;
			active_q <= mnpt_pkg::NOTE_NONE;
			avel_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			held_q <= held_d;
			total_q <= total_d;
			active_q <= active_d;
			avel_q <= avel_d;
			out_valid_q <= load_res || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mnpt_pkg::BK_SCAN) begin
			grp_any_s1 <= grp_any;
			grp_idx_s1 <= grp_idx;
		end
		if (load_res) begin
			ev_kind_q <= ev_kind_d;
			ev_note_q <= ev_note_d;
			ev_vel_q <= ev_vel_d;
			res_cnt_q <= total_d;
			res_cur_q <= active_d;
			res_vel_q <= avel_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.event_kind = ev_kind_q;
	assign res.event_note = ev_note_q;
	assign res.event_velocity = ev_vel_q;
	assign res.held_count = res_cnt_q;
	assign res.current_note = res_cur_q;
	assign res.current_velocity = res_vel_q;

	// count always matches the bitmap
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(held_q) == int'(total_q))
		else $error("held count differs from bitmap");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= KEY_LIMIT)
		else $error("held count above key range");

	// no current note exactly when nothing is held
	a_none_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0) == (active_q == mnpt_pkg::NOTE_NONE))
		else $error("current note disagrees with held count");

	// while a search runs the released note is still current, so only checked when idle
	a_current_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mnpt_pkg::BK_IDLE && active_q != mnpt_pkg::NOTE_NONE)
		|-> held_q[active_q[KW-1:0]])
		else $error("current note is not held");

	// search start frees the result register, so the pick never overwrites
	a_pick_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start |=> !out_valid_q ##1 (state_q == mnpt_pkg::BK_PICK && !out_valid_q))
		else $error("result register busy at pick");

endmodule

// ----- hdl/mono_note_priority_tracker.sv -----
// an accepted event passes the queue, then the back end loads its result into the output register
// throughput: one event per cycle while results are taken, except a release that leaves keys held,
// which occupies the back end for the two-step highest-key search (group encoders, then group select)
// a 2-entry queue decouples acceptance from the back end; results wait in an output register
// reset (arst_n low, asynchronous): no keys held, count 0, current note -1, velocity 0,
// queue and output register empty
module mono_note_priority_tracker #(
	parameter int NUM_KEYS = mnpt_pkg::NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mnpt_evt_if.sink    evt,
	mnpt_res_if.source  res
);

	mnpt_pkg::op_t push_op;
	mnpt_pkg::op_t head_op;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;

	mnpt_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.evt    (evt),
		.q_full (q_full),
		.push   (push),
		.op     (push_op)
	);

	mnpt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	mnpt_back #(
		.NUM_KEYS (NUM_KEYS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_op (head_op),
		.q_empty (q_empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
